// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check with reset masking
`define CHK_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/iplpm_pkg.sv =====
`timescale 1ns / 1ps
package iplpm_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = IDX_W + 1;
    localparam int STAMP_W = 40;
    localparam logic [7:0] FULL_LEN = 8'd128;

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_LOOKUP = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_BADLEN   = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic start;
        logic step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic last_read;
        logic out_free;
    } stat_t;

    typedef struct packed {
        logic [127:0]       prefix;
        logic [7:0]         len;
        logic [127:0]       gw;
        logic [7:0]         port;
        logic [31:0]        cost;
        logic [STAMP_W-1:0] stamp;
    } row_t;

    function automatic logic [127:0] pfx_mask(input logic [7:0] len);
        return ~({128{1'b1}} >> len);
    endfunction

endpackage

// ===== rtl/iplpm_ctrl.sv =====
`timescale 1ns / 1ps
module iplpm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  iplpm_pkg::stat_t    stat,
    output iplpm_pkg::cmd_t     cmd
);
    import iplpm_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_TAIL   = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // rejected items skip the table walk
                if (stat.skip)
                begin
                    state_next = S_COMMIT;
                end
                else
                begin
                    cmd.step = 1'b1;
                    if (stat.last_read)
                    begin
                        state_next = S_TAIL;
                    end
                end
            end
            S_TAIL:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/iplpm_dp.sv =====
`timescale 1ns / 1ps
module iplpm_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          s_tuser,
    input  logic [311:0]        s_tdata,
    input  iplpm_pkg::cmd_t     cmd,
    output iplpm_pkg::stat_t    stat,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [1:0]          m_tuser,
    output logic [175:0]        m_tdata
);
    import iplpm_pkg::*;

    row_t               mem [ENTRIES];
    row_t               rd_row_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;

    logic [1:0]         act_reg;
    logic [127:0]       addr_reg;
    logic [7:0]         len_reg;
    logic [127:0]       gw_reg;
    logic [7:0]         port_reg;
    logic [31:0]        cost_reg;
    logic               skip_reg;
    logic [1:0]         skip_st_reg;
    logic [STAMP_W-1:0] stamp_reg;

    logic [CNT_W-1:0]   rd_idx_reg;
    logic               pend_reg;
    logic [IDX_W-1:0]   pend_idx_reg;

    logic               dup_found_reg;
    logic [IDX_W-1:0]   dup_idx_reg;
    logic               free_found_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic               best_found_reg;
    row_t               best_reg;

    logic               out_valid_reg;
    logic [1:0]         out_st_reg;
    logic [175:0]       out_data_reg;

    logic               cur_valid;
    logic               exact_hit;
    logic               pfx_hit;
    logic               better;
    logic               use_free;
    logic               have_slot;
    logic [IDX_W-1:0]   slot;
    logic [7:0]         in_len;
    logic [1:0]         in_act;

    assign in_act = s_tuser;
    assign in_len = s_tdata[135:128];

    assign cur_valid = valid_reg[pend_idx_reg];
    assign exact_hit = cur_valid && rd_row_reg.len == len_reg &&
                       rd_row_reg.prefix == addr_reg;
    assign pfx_hit   = cur_valid &&
                       ((rd_row_reg.prefix ^ addr_reg) & pfx_mask(rd_row_reg.len)) == '0;
    assign better    = !best_found_reg || rd_row_reg.len > best_reg.len ||
                       (rd_row_reg.len == best_reg.len && rd_row_reg.stamp > best_reg.stamp);

    // lowest free slot, counting a removed duplicate as free
    assign use_free  = free_found_reg && (!dup_found_reg || free_idx_reg < dup_idx_reg);
    assign have_slot = free_found_reg || dup_found_reg;
    assign slot      = use_free ? free_idx_reg : dup_idx_reg;

    assign stat.skip      = skip_reg;
    assign stat.last_read = rd_idx_reg == CNT_W'(ENTRIES - 1);
    assign stat.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_st_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.commit && !skip_reg && act_reg != ACT_LOOKUP)
        begin
            if (dup_found_reg)
            begin
                valid_next[dup_idx_reg] = 1'b0;
            end
            if (act_reg == ACT_ADD && have_slot)
            begin
                valid_next[slot] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            rd_row_reg <= mem[rd_idx_reg[IDX_W-1:0]];
        end
        if (cmd.commit && !skip_reg && act_reg == ACT_ADD && have_slot)
        begin
            mem[slot] <= '{prefix: addr_reg, len: len_reg, gw: gw_reg,
                           port: port_reg, cost: cost_reg, stamp: stamp_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            act_reg  <= in_act;
            addr_reg <= {s_tdata[63:0], s_tdata[127:64]};
            len_reg  <= in_len;
            gw_reg   <= s_tdata[136] ? {s_tdata[200:137], s_tdata[264:201]} : 128'd0;
            port_reg <= s_tdata[272:265];
            cost_reg <= s_tdata[304:273];
        end
        if (pend_reg && pfx_hit && better)
        begin
            best_reg <= rd_row_reg;
        end
        if (pend_reg && exact_hit && !dup_found_reg)
        begin
            dup_idx_reg <= pend_idx_reg;
        end
        if (pend_reg && !cur_valid && !free_found_reg)
        begin
            free_idx_reg <= pend_idx_reg;
        end
        if (cmd.commit)
        begin
            if (skip_reg)
            begin
                out_st_reg   <= skip_st_reg;
                out_data_reg <= '0;
            end
            else
            begin
                case (act_reg)
                    ACT_ADD:
                    begin
                        out_st_reg   <= have_slot ? ST_OK : ST_FULL;
                        out_data_reg <= '0;
                    end
                    ACT_DELETE:
                    begin
                        out_st_reg   <= dup_found_reg ? ST_OK : ST_NOTFOUND;
                        out_data_reg <= '0;
                    end
                    default:
                    begin
                        out_st_reg   <= best_found_reg ? ST_OK : ST_NOTFOUND;
                        out_data_reg <= best_found_reg ?
                                        {best_reg.cost, best_reg.port,
                                         best_reg.gw[63:0], best_reg.gw[127:64],
                                         best_reg.len} : 176'd0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            stamp_reg      <= '0;
            rd_idx_reg     <= '0;
            pend_reg       <= 1'b0;
            pend_idx_reg   <= '0;
            dup_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
            skip_reg       <= 1'b0;
            skip_st_reg    <= ST_OK;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            pend_reg     <= cmd.step;
            pend_idx_reg <= rd_idx_reg[IDX_W-1:0];
            if (cmd.start)
            begin
                rd_idx_reg     <= '0;
                dup_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
                best_found_reg <= 1'b0;
                if (in_act == ACT_ADD && in_len > FULL_LEN)
                begin
                    skip_reg    <= 1'b1;
                    skip_st_reg <= ST_BADLEN;
                end
                else if (!(in_act inside {ACT_ADD, ACT_DELETE, ACT_LOOKUP}))
                begin
                    skip_reg    <= 1'b1;
                    skip_st_reg <= ST_NOTFOUND;
                end
                else
                begin
                    skip_reg    <= 1'b0;
                    skip_st_reg <= ST_OK;
                end
            end
            else if (cmd.step)
            begin
                rd_idx_reg <= rd_idx_reg + CNT_W'(1);
            end
            if (pend_reg)
            begin
                if (exact_hit)
                begin
                    dup_found_reg <= 1'b1;
                end
                if (!cur_valid)
                begin
                    free_found_reg <= 1'b1;
                end
                if (pfx_hit)
                begin
                    best_found_reg <= 1'b1;
                end
            end
            if (cmd.commit && !skip_reg && act_reg == ACT_ADD && have_slot)
            begin
                stamp_reg <= stamp_reg + STAMP_W'(1);
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/ipv6_longest_prefix_route_table.sv =====
`timescale 1ns / 1ps
// Route table of 64 IPv6 entries with add, delete and longest-prefix lookup.
// Every add, delete and lookup that is not rejected walks all 64 rows of the
// entry memory, one read a cycle, before its result beat is given; an add with
// a length above 128 or an unused action code is rejected and skips the walk.
// The memory's single read port sets this read rate. Items are taken one at a
// time; a result waiting in the output register does not hold off the next
// item. Ties between equal-length matches go to the newest add.
`include "assert_macros.svh"
module ipv6_longest_prefix_route_table (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    // action
    input  logic [1:0]    s_tuser,
    // addr_hi, addr_lo, pfx_length, has_gateway, gateway_hi, gateway_lo,
    // port_id, route_cost, zero pad
    input  logic [311:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // status
    output logic [1:0]    m_tuser,
    // match_len, hop_hi, hop_lo, out_port, out_cost
    output logic [175:0]  m_tdata
);
    import iplpm_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    iplpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    iplpm_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    `CHK_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted while busy")
    `CHK_IMPL(a_result_from_commit, $rose(m_tvalid), $past(cmd.commit), "stray result beat")
    `CHK_IMPL(a_commit_needs_room, cmd.commit, stat.out_free, "result overwritten")

endmodule
